// ===== rtl/core/frame_fifo_drop_oldest_top_defines.svh =====
// assertion macros for the frame fifo with drop-oldest overflow
// used by frame_fifo_drop_oldest_top; expects signals named clock and reset in scope
`ifndef FRAME_FIFO_DROP_OLDEST_TOP_DEFINES_SVH
`define FRAME_FIFO_DROP_OLDEST_TOP_DEFINES_SVH

// checked only outside reset
`define FFDO_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge
`define FFDO_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/ffdo_pkg.sv =====
// shared types and constants of the frame fifo with drop-oldest overflow
// no dependencies
`default_nettype none

package ffdo_pkg;

   localparam int DEPTH_FRAMES = 1024;
   localparam int MAX_CHANNELS = 4;
   localparam int SAMPLE_W     = 32;
   localparam int LANES        = 4;
   localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
   localparam int CNT_W        = $clog2(DEPTH_FRAMES + 1);
   localparam int FRAME_W      = MAX_CHANNELS * SAMPLE_W;
   localparam int BURST_W      = 16;
   localparam int CAP_CFG_W    = 11;
   localparam int CHAN_CFG_W   = 3;
   localparam int FILL_W       = 11;
   localparam int COUNT_W      = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CAP_RESET    = 1024;
   localparam int CHAN_RESET   = 2;

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } action_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_CHANNELS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic present;
   } pend_type;

endpackage

`default_nettype wire

// ===== rtl/core/ffdo_if.sv =====
// request and response channel interfaces of the frame fifo
// depends on ffdo_pkg
`default_nettype none

interface ffdo_req_if;
   import ffdo_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic                       first_of_burst;
   logic [BURST_W-1:0]         burst_frames;
   logic signed [SAMPLE_W-1:0] sample_0;
   logic signed [SAMPLE_W-1:0] sample_1;
   logic signed [SAMPLE_W-1:0] sample_2;
   logic signed [SAMPLE_W-1:0] sample_3;

   modport source (output valid, action, first_of_burst, burst_frames,
                   sample_0, sample_1, sample_2, sample_3, input ready);
   modport sink (input valid, action, first_of_burst, burst_frames,
                 sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

interface ffdo_rsp_if;
   import ffdo_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample_0;
   logic signed [SAMPLE_W-1:0] out_sample_1;
   logic signed [SAMPLE_W-1:0] out_sample_2;
   logic signed [SAMPLE_W-1:0] out_sample_3;
   logic                       frame_present;
   logic [FILL_W-1:0]          fill_level;
   logic [COUNT_W-1:0]         overrun_total;
   logic [COUNT_W-1:0]         underflow_total;
   logic [COUNT_W-1:0]         dropped_total;

   modport source (output valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
                   frame_present, fill_level, overrun_total, underflow_total,
                   dropped_total, input ready);
   modport sink (input valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
                 frame_present, fill_level, overrun_total, underflow_total,
                 dropped_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffdo_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ffdo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/frame_fifo_drop_oldest_top.sv =====
// frame fifo of multichannel audio frames that drops the oldest frame on overflow
// usage: req_bus carries push and pop requests, one response per request on rsp_bus.
// a push stores one frame; the first request of a push burst carries the burst length,
// leading frames beyond capacity are discarded and a full fifo pushes out its oldest frame.
// a pop returns the oldest frame, or zeros when empty; lanes at or above the channel
// count in effect (setting clamped to 1..4) read zero. every response also carries fill
// level and the overrun, underflow and dropped counters, which wrap at 32 bits.
// a request passes the pending stage with the ram read, then the response register.
// throughput: one request per cycle, set by the single frame ram (one write and one
// read port, registered read) and one update of the pointers per cycle.
// a stalled receiver holds the response register; one more request can be taken
// while it waits, after that req_bus.ready drops until the response is taken.
// reset empties the fifo, clears the counters and loads capacity 1024 and 2 channels;
// the ram is not cleared, no clearing pass is needed.
// csr port: capacity register at 0x0, channel register at 0x4; a write empties the fifo
// but keeps the counters. write only while no request is outstanding.
// depends on ffdo_pkg, ffdo_if, ffdo_ram and the defines header
`default_nettype none
`include "frame_fifo_drop_oldest_top_defines.svh"

module frame_fifo_drop_oldest_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ffdo_req_if.sink                              req_bus,
   ffdo_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ffdo_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ffdo_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [ffdo_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                             csr_pready
);
   import ffdo_pkg::*;

   // configuration
   logic [CAP_CFG_W-1:0]  cap_cfg_ff, cap_cfg_in;
   logic [CHAN_CFG_W-1:0] chan_cfg_ff, chan_cfg_in;
   logic [CNT_W-1:0]      cap_eff;
   logic [CHAN_CFG_W-1:0] chans_eff;
   logic [31:0]           cap_wide, chan_wide;
   logic                  csr_wr;

   // fifo state
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [BURST_W-1:0] skip_ff, skip_in;
   logic [COUNT_W-1:0] ovr_ff, ovr_in, unf_ff, unf_in, drop_ff, drop_in;

   // request side
   logic               req_fire;
   logic               is_pop;
   logic [BURST_W:0]   burst_x, cap_x, held_x, acc_x, free_x;
   logic [BURST_W-1:0] skip_new, skip_cur;
   logic               ovr_a, ovr_b;
   logic [ADDR_W:0]    idx_step, slot_sum;
   logic [ADDR_W-1:0]  slot;
   logic [ADDR_W-1:0]  idx_tmp;
   logic [CNT_W-1:0]   held_tmp;

   // ram
   logic               ram_we, ram_re;
   logic [FRAME_W-1:0] ram_wdata, ram_rdata;
   logic signed [SAMPLE_W-1:0] in_lane [LANES];

   // pipeline and response
   logic     p_valid_ff;
   pend_type p_ff, p_in;
   logic     p_move;
   logic     rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] lane_ff [LANES];
   logic signed [SAMPLE_W-1:0] lane_in [LANES];
   logic                       present_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic [COUNT_W-1:0]         ovr_out_ff, unf_out_ff, drop_out_ff;

   // effective configuration
   always_comb begin
      cap_wide  = 32'(cap_cfg_ff);
      chan_wide = 32'(chan_cfg_ff);
      if (cap_wide == 32'd0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_wide > 32'(DEPTH_FRAMES)) begin
         cap_eff = CNT_W'(DEPTH_FRAMES);
      end else begin
         cap_eff = CNT_W'(cap_wide);
      end
      if (chan_wide == 32'd0) begin
         chans_eff = CHAN_CFG_W'(1);
      end else if (chan_wide > 32'(MAX_CHANNELS)) begin
         chans_eff = CHAN_CFG_W'(MAX_CHANNELS);
      end else begin
         chans_eff = CHAN_CFG_W'(chan_wide);
      end
   end

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_cfg_in  = cap_cfg_ff;
      chan_cfg_in = chan_cfg_ff;
      if (csr_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_CAPACITY: cap_cfg_in  = csr_pwdata[CAP_CFG_W-1:0];
            REG_CHANNELS: chan_cfg_in = csr_pwdata[CHAN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_CAPACITY: csr_prdata = CSR_DATA_W'(cap_cfg_ff);
         REG_CHANNELS: csr_prdata = CSR_DATA_W'(chan_cfg_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // handshake
   assign p_move        = p_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !p_valid_ff || p_move;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign is_pop        = (req_bus.action == ACT_POP);

   assign in_lane[0] = req_bus.sample_0;
   assign in_lane[1] = req_bus.sample_1;
   assign in_lane[2] = req_bus.sample_2;
   assign in_lane[3] = req_bus.sample_3;

   always_comb begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         ram_wdata[c*SAMPLE_W +: SAMPLE_W] = in_lane[c];
      end
   end

   // request update: pointers, counters and ram access
   always_comb begin
      rd_idx_in = rd_idx_ff;
      held_in   = held_ff;
      skip_in   = skip_ff;
      ovr_in    = ovr_ff;
      unf_in    = unf_ff;
      drop_in   = drop_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      p_in      = p_ff;

      burst_x  = (BURST_W+1)'(req_bus.burst_frames);
      cap_x    = (BURST_W+1)'(cap_eff);
      held_x   = (BURST_W+1)'(held_ff);
      skip_new = (burst_x > cap_x) ? BURST_W'(burst_x - cap_x) : '0;
      acc_x    = burst_x - (BURST_W+1)'(skip_new);
      free_x   = cap_x - held_x;
      ovr_a    = (skip_new != '0);
      ovr_b    = (acc_x > free_x);
      skip_cur = req_bus.first_of_burst ? skip_new : skip_ff;

      idx_step = (ADDR_W+1)'(rd_idx_ff) + (ADDR_W+1)'(1);
      idx_tmp  = (idx_step >= (ADDR_W+1)'(cap_eff)) ? '0 : idx_step[ADDR_W-1:0];
      held_tmp = held_ff;
      slot_sum = '0;
      slot     = '0;

      if (req_fire) begin
         p_in.present = 1'b0;
         if (!is_pop) begin
            if (req_bus.first_of_burst) begin
               ovr_in = ovr_ff + COUNT_W'(ovr_a) + COUNT_W'(ovr_b);
            end
            if (skip_cur != '0) begin
               // leading frames of an oversized burst are discarded
               skip_in = skip_cur - BURST_W'(1);
               drop_in = drop_ff + COUNT_W'(1);
            end else begin
               skip_in = '0;
               if (held_ff >= cap_eff) begin
                  // full: push out the oldest frame
                  rd_idx_in = idx_tmp;
                  held_tmp  = held_ff - CNT_W'(1);
                  drop_in   = drop_ff + COUNT_W'(1);
               end
               slot_sum = (ADDR_W+1)'(rd_idx_in) + (ADDR_W+1)'(held_tmp);
               if (slot_sum >= (ADDR_W+1)'(cap_eff)) begin
                  slot_sum = slot_sum - (ADDR_W+1)'(cap_eff);
               end
               slot    = slot_sum[ADDR_W-1:0];
               ram_we  = 1'b1;
               held_in = held_tmp + CNT_W'(1);
            end
         end else begin
            if (req_bus.first_of_burst && (held_x < burst_x)) begin
               unf_in = unf_ff + COUNT_W'(1);
            end
            if (held_ff != '0) begin
               ram_re       = 1'b1;
               rd_idx_in    = idx_tmp;
               held_in      = held_ff - CNT_W'(1);
               p_in.present = 1'b1;
            end
         end
      end

      // any register write empties the fifo
      if (csr_wr) begin
         rd_idx_in = '0;
         held_in   = '0;
         skip_in   = '0;
      end
   end

   ffdo_ram #(
      .WIDTH(FRAME_W),
      .DEPTH(DEPTH_FRAMES)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(slot),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(rd_idx_ff),
      .rd_data(ram_rdata)
   );

   // response lanes from the ram data
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         lane_in[c] = '0;
      end
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (p_ff.present && (c < int'(chans_eff))) begin
            lane_in[c] = ram_rdata[c*SAMPLE_W +: SAMPLE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_cfg_ff   <= CAP_CFG_W'(CAP_RESET);
         chan_cfg_ff  <= CHAN_CFG_W'(CHAN_RESET);
         rd_idx_ff    <= '0;
         held_ff      <= '0;
         skip_ff      <= '0;
         ovr_ff       <= '0;
         unf_ff       <= '0;
         drop_ff      <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_cfg_ff  <= cap_cfg_in;
         chan_cfg_ff <= chan_cfg_in;
         rd_idx_ff   <= rd_idx_in;
         held_ff     <= held_in;
         skip_ff     <= skip_in;
         ovr_ff      <= ovr_in;
         unf_ff      <= unf_in;
         drop_ff     <= drop_in;
         if (req_fire) begin
            p_valid_ff <= 1'b1;
         end else if (p_move) begin
            p_valid_ff <= 1'b0;
         end
         if (p_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers; counters and fill are read while the stage moves, before
   // a request taken in the same cycle changes them
   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (p_move) begin
         for (int c = 0; c < LANES; c++) begin
            lane_ff[c] <= lane_in[c];
         end
         present_ff  <= p_ff.present;
         fill_ff     <= FILL_W'(held_ff);
         ovr_out_ff  <= ovr_ff;
         unf_out_ff  <= unf_ff;
         drop_out_ff <= drop_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.out_sample_0    = lane_ff[0];
   assign rsp_bus.out_sample_1    = lane_ff[1];
   assign rsp_bus.out_sample_2    = lane_ff[2];
   assign rsp_bus.out_sample_3    = lane_ff[3];
   assign rsp_bus.frame_present   = present_ff;
   assign rsp_bus.fill_level      = fill_ff;
   assign rsp_bus.overrun_total   = ovr_out_ff;
   assign rsp_bus.underflow_total = unf_out_ff;
   assign rsp_bus.dropped_total   = drop_out_ff;

   `FFDO_ASSERT(a_held_within_cap, held_ff <= cap_eff, "frames held exceed capacity")
   `FFDO_ASSERT(a_index_within_cap, (ADDR_W+1)'(rd_idx_ff) < cap_eff, "read index out of range")
   `FFDO_ASSERT(a_pop_present, ram_re |=> p_ff.present, "pop of a held frame lost its frame")
   `FFDO_ASSERT(a_push_absent, req_fire && !is_pop |=> !p_ff.present, "push marked present")
   `FFDO_ASSERT(a_drop_needs_request, drop_ff != $past(drop_ff) |-> $past(req_fire), "stray drop")

endmodule

`default_nettype wire

// ===== tb/sv/frame_fifo_drop_oldest_check.sv =====
`timescale 1ns / 1ps
// checker for the frame fifo: watches request, response and csr traffic, predicts each
// response from its own model of the ring and compares field by field
// depends on ffdo_pkg and ffdo_if
module frame_fifo_drop_oldest_check
   import ffdo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ffdo_req_if                   req_bus,
   ffdo_rsp_if                   rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    answers_left
);

   typedef struct packed {
      logic [LANES-1:0][SAMPLE_W-1:0] lanes;
      logic                           present;
      logic [FILL_W-1:0]              fill;
      logic [COUNT_W-1:0]             overruns;
      logic [COUNT_W-1:0]             underflows;
      logic [COUNT_W-1:0]             drops;
   } fifo_answer_type;

   logic [LANES-1:0][SAMPLE_W-1:0] frames [DEPTH_FRAMES];
   int unsigned                    rd_ptr;
   int unsigned                    held;
   int unsigned                    skip_left;
   logic [COUNT_W-1:0]             overruns;
   logic [COUNT_W-1:0]             underflows;
   logic [COUNT_W-1:0]             drops;
   logic [CAP_CFG_W-1:0]           cap_cfg;
   logic [CHAN_CFG_W-1:0]          chan_cfg;
   fifo_answer_type                answers_due[$];
   fifo_answer_type                due;

   function automatic fifo_answer_type advance_fifo(input action_type act, input logic first,
                                                    input logic [BURST_W-1:0] burst,
                                                    input logic [LANES-1:0][SAMPLE_W-1:0] frame);
      fifo_answer_type ans;
      int unsigned  cap;
      int unsigned  chans;
      int unsigned  skip;
      int unsigned  taken;
      int unsigned  slot;
      ans = '0;
      cap = (cap_cfg == 0) ? 1 : (cap_cfg > DEPTH_FRAMES) ? DEPTH_FRAMES : cap_cfg;
      chans = (chan_cfg == 0) ? 1 : (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg;
      if (act == ACT_PUSH) begin
         if (first) begin
            // leading frames beyond capacity are thrown away as they arrive
            skip = (burst > cap) ? burst - cap : 0;
            taken = burst - skip;
            skip_left = skip;
            if (skip != 0) overruns++;
            if (taken > cap - held) overruns++;
         end
         if (skip_left > 0) begin
            skip_left--;
            drops++;
         end else begin
            if (held >= cap) begin
               rd_ptr = (rd_ptr + 1) % cap;
               held--;
               drops++;
            end
            slot = (rd_ptr + held) % cap;
            frames[slot] = frame;
            held++;
         end
      end else begin
         if (first && held < burst) underflows++;
         if (held > 0) begin
            for (int c = 0; c < chans; c++) ans.lanes[c] = frames[rd_ptr][c];
            rd_ptr = (rd_ptr + 1) % cap;
            held--;
            ans.present = 1'b1;
         end
      end
      ans.fill = FILL_W'(held);
      ans.overruns = overruns;
      ans.underflows = underflows;
      ans.drops = drops;
      return ans;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rd_ptr = 0;
         held = 0;
         skip_left = 0;
         overruns = '0;
         underflows = '0;
         drops = '0;
         cap_cfg = CAP_CFG_W'(CAP_RESET);
         chan_cfg = CHAN_CFG_W'(CHAN_RESET);
         answers_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               check_field("out_sample_0", due.lanes[0], rsp_bus.out_sample_0);
               check_field("out_sample_1", due.lanes[1], rsp_bus.out_sample_1);
               check_field("out_sample_2", due.lanes[2], rsp_bus.out_sample_2);
               check_field("out_sample_3", due.lanes[3], rsp_bus.out_sample_3);
               check_field("frame_present", 32'(due.present), 32'(rsp_bus.frame_present));
               check_field("fill_level", 32'(due.fill), 32'(rsp_bus.fill_level));
               check_field("overrun_total", due.overruns, rsp_bus.overrun_total);
               check_field("underflow_total", due.underflows, rsp_bus.underflow_total);
               check_field("dropped_total", due.drops, rsp_bus.dropped_total);
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            answers_due.push_back(advance_fifo(action_type'(req_bus.action),
                                               req_bus.first_of_burst, req_bus.burst_frames,
                                               {req_bus.sample_3, req_bus.sample_2,
                                                req_bus.sample_1, req_bus.sample_0}));
         end
         // any register write empties the ring, counters survive
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_CAPACITY: cap_cfg = csr_pwdata[CAP_CFG_W-1:0];
               REG_CHANNELS: chan_cfg = csr_pwdata[CHAN_CFG_W-1:0];
               default: ;
            endcase
            rd_ptr = 0;
            held = 0;
            skip_left = 0;
         end
      end
      answers_left = answers_due.size();
   end

endmodule

// ===== tb/sv/frame_fifo_drop_oldest_top_tb.sv =====
`timescale 1ns / 1ps
// top of the frame fifo testbench: clock, reset, csr writes, push and pop stimulus and verdict
// depends on ffdo_pkg, ffdo_if, frame_fifo_drop_oldest_top and frame_fifo_drop_oldest_check
module frame_fifo_drop_oldest_top_tb;
   import ffdo_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 108;

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC
   } rx_style_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    answers_left;
   int unsigned           cycle_count;

   bit                    sender_bursty;
   int unsigned           burst_left;
   rx_style_type          rx_mode;
   int unsigned           rx_period;
   int unsigned           rx_low;
   bit                    hold_request;
   int unsigned           cap_now;

   int unsigned cap_plan[PHASES]  = '{1, 0, 2, 3, 2047, 5, 8, 1024, 16, 7, 1500, 4};
   int unsigned chan_plan[PHASES] = '{1, 4, 0, 3, 7, 2, 4, 5, 1, 6, 4, 2};

   ffdo_req_if req_bus();
   ffdo_rsp_if rsp_bus();

   frame_fifo_drop_oldest_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_fifo_drop_oldest_check u_check (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .answers_left (answers_left)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("frame_fifo_drop_oldest_top_tb: done, errors");
         $finish;
      end
   end

   // response side: open, random or periodic stalls, plus one long hold-off on request
   initial begin
      int unsigned tick;
      tick = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         case (rx_mode)
            RX_OPEN:   rsp_bus.ready = 1'b1;
            RX_RANDOM: rsp_bus.ready = ($urandom_range(0, 3) != 0);
            default:   rsp_bus.ready = ((tick % rx_period) >= rx_low);
         endcase
      end
   end

   function automatic logic [FRAME_W-1:0] rand_frame();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // called and returns at a falling edge; valid stays high into a gapless next request
   task automatic offer(input action_type act, input logic first,
                        input logic [BURST_W-1:0] burst, input logic [FRAME_W-1:0] frame);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_bursty ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid = 1'b1;
      req_bus.action = act;
      req_bus.first_of_burst = first;
      req_bus.burst_frames = burst;
      req_bus.sample_0 = frame[0*SAMPLE_W +: SAMPLE_W];
      req_bus.sample_1 = frame[1*SAMPLE_W +: SAMPLE_W];
      req_bus.sample_2 = frame[2*SAMPLE_W +: SAMPLE_W];
      req_bus.sample_3 = frame[3*SAMPLE_W +: SAMPLE_W];
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (answers_left != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // well-formed push and pop bursts with random content, some cut short, some noise
   task automatic run_phase(input int unsigned quota);
      int unsigned sent;
      int unsigned pick;
      int unsigned span;
      int unsigned len;
      int unsigned nsend;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         span = (cap_now < 20) ? cap_now + 3 : 24;
         len = $urandom_range(1, span);
         nsend = len;
         if ($urandom_range(0, 7) == 0) nsend = $urandom_range(1, len);
         if ($urandom_range(0, 24) == 0) begin
            len = 0;
            nsend = $urandom_range(1, 4);
         end
         if (pick < 45) begin
            if ($urandom_range(0, 15) == 0) begin
               len = $urandom_range(1024, 65535);
               nsend = $urandom_range(1, 6);
            end
            for (int k = 0; k < nsend; k++)
               offer(ACT_PUSH, k == 0, (k == 0) ? 16'(len) : 16'($urandom), rand_frame());
         end else if (pick < 88) begin
            for (int k = 0; k < nsend; k++)
               offer(ACT_POP, k == 0, (k == 0) ? 16'(len) : 16'($urandom), rand_frame());
         end else begin
            nsend = 1;
            offer(action_type'(1'($urandom)), 1'($urandom), 16'($urandom), rand_frame());
         end
         sent += nsend;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_PUSH;
      req_bus.first_of_burst = 1'b0;
      req_bus.burst_frames = '0;
      req_bus.sample_0 = '0;
      req_bus.sample_1 = '0;
      req_bus.sample_2 = '0;
      req_bus.sample_3 = '0;
      cycle_count = 0;
      sender_bursty = 1'b1;
      burst_left = 0;
      rx_mode = RX_RANDOM;
      rx_period = 5;
      rx_low = 2;
      hold_request = 1'b0;
      cap_now = CAP_RESET;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed part at the reset settings
      offer(ACT_POP, 1'b1, 16'd1, rand_frame());
      offer(ACT_POP, 1'b1, 16'd0, rand_frame());
      offer(ACT_PUSH, 1'b1, 16'd0, {32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff});
      offer(ACT_PUSH, 1'b0, 16'hffff, {32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff});
      offer(ACT_POP, 1'b1, 16'd2, rand_frame());
      offer(ACT_POP, 1'b0, 16'h0, rand_frame());
      offer(ACT_POP, 1'b0, 16'h0, rand_frame());
      offer(ACT_PUSH, 1'b1, 16'hffff, rand_frame());
      offer(ACT_PUSH, 1'b0, 16'h0, rand_frame());
      offer(ACT_PUSH, 1'b0, 16'h5a5a, rand_frame());
      // a new burst start replaces the pending skip
      offer(ACT_PUSH, 1'b1, 16'd1025, rand_frame());
      offer(ACT_PUSH, 1'b0, 16'h0, rand_frame());
      offer(ACT_PUSH, 1'b1, 16'd1024, rand_frame());
      offer(ACT_POP, 1'b1, 16'd3, rand_frame());
      offer(ACT_POP, 1'b1, 16'd1, rand_frame());
      offer(ACT_POP, 1'b0, 16'h0, rand_frame());

      cap_plan[PHASES-1] = $urandom_range(0, 2047);
      chan_plan[PHASES-1] = $urandom_range(0, 7);
      for (int p = 0; p < PHASES; p++) begin
         drain();
         csr_write(REG_CAPACITY, {21'($urandom), 11'(cap_plan[p])});
         csr_write(REG_CHANNELS, {29'($urandom), 3'(chan_plan[p])});
         cap_now = (cap_plan[p] == 0) ? 1 :
                   (cap_plan[p] > DEPTH_FRAMES) ? DEPTH_FRAMES : cap_plan[p];
         sender_bursty = (p % 3 != 1);
         rx_mode = rx_style_type'(p % 3);
         rx_period = $urandom_range(3, 9);
         rx_low = $urandom_range(1, rx_period - 1);
         // one long receiver hold-off while the sender keeps pushing
         if (p == 2) begin
            sender_bursty = 1'b0;
            hold_request = 1'b1;
         end
         run_phase(PHASE_ITEMS);
      end
      drain();

      if (mismatches == 0 && answers_left == 0)
         $display("frame_fifo_drop_oldest_top_tb: done, clean");
      else
         $display("frame_fifo_drop_oldest_top_tb: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ffdo_pkg.sv
rtl/core/ffdo_if.sv
rtl/core/ffdo_ram.sv
rtl/core/frame_fifo_drop_oldest_top.sv
tb/sv/frame_fifo_drop_oldest_check.sv
tb/sv/frame_fifo_drop_oldest_top_tb.sv
